// File: design/bba_pkg.sv
// ============================================================================
// bba_pkg - shared definitions for the bitmap block allocator
// Field widths, default sizes, request and status codes, sequencer states.
// ============================================================================
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  localparam int TOTAL_W = 13;
  localparam int BLK_W   = 12;
  localparam int STAT_W  = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FRD   = 6'b001000,
    S_FCHK  = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

endpackage

// File: design/bitmap_block_allocator.sv
// ============================================================================
// bitmap_block_allocator - first-fit block allocator over a usage bitmap
// Allocates the lowest free block below the configured count, frees blocks
// with range and double-free checks, one result per request.
// ============================================================================
//
//  channel   direction  signals                                  handshake
//  --------  ---------  ---------------------------------------  -----------
//  cfg       in         cfg_we_i, cfg_wdata_i (total_blocks)     write only
//  in        in         req_type_i, block_number_i               valid/ready
//  out       out        status_o, granted_block_o                valid/ready
//
//  Allocate: accept, then scan the bitmap words one word per cycle through the
//  read port of the bitmap RAM, up to a free block or the last word; result.
//  Free: accept, read, check and write back, result. A free out of
//  range and an allocate with a zero block count answer without a RAM access.
//  After reset the bitmap RAM is cleared one word per cycle, with in_ready_o
//  low; cfg writes are taken throughout.
//  A finished result waits in the output register; the next transaction is
//  accepted meanwhile and only stalls at its own completion.
//
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [BLK_W-1:0]   block_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [BLK_W-1:0]   granted_block_o
);

  localparam int MAP_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LOG_WB    = $clog2(WORD_BITS);
  localparam int CAP_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W     = (CAP_W > TOTAL_W) ? CAP_W : TOTAL_W;

  state_e state_q, state_d;

  logic [TOTAL_W-1:0]   total_q;
  logic [AW-1:0]        clr_q, clr_d;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic [AW-1:0]        chk_addr_q, chk_addr_d;
  logic                 pend_q, pend_d;
  logic [LOG_WB-1:0]    bit_q, bit_d;
  status_e              res_status_q, res_status_d;
  logic [CNT_W-1:0]     res_block_q, res_block_d;
  logic                 out_valid_q, out_valid_d;
  logic [STAT_W-1:0]    out_status_q, out_status_d;
  logic [BLK_W-1:0]     out_block_q, out_block_d;

  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     total_ext;
  logic [CNT_W-1:0]     blk_ext;
  logic [CNT_W-1:0]     base;
  logic                 last_word;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 scan_found;
  logic [LOG_WB-1:0]    scan_idx;
  logic [WORD_BITS-1:0] scan_onehot;
  logic [WORD_BITS-1:0] free_mask;
  logic                 out_load;

  // block count clamps to capacity
  assign total_ext = CNT_W'(total_q);
  assign lim       = (total_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_ext;
  assign blk_ext   = CNT_W'(block_number_i);

  // block number of bit 0 of the word under check
  assign base      = CNT_W'(chk_addr_q) << LOG_WB;
  assign last_word = (base + CNT_W'(WORD_BITS)) >= lim;
  assign free_mask = WORD_BITS'(1) << bit_q;

  bba_map_ram #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (MAP_WORDS),
    .AW        (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  bba_scan #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W),
    .LOG_WB    (LOG_WB)
  ) u_scan (
    .word_i   (ram_rdata),
    .base_i   (base),
    .lim_i    (lim),
    .found_o  (scan_found),
    .idx_o    (scan_idx),
    .onehot_o (scan_onehot)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rd_addr_d    = rd_addr_q;
    chk_addr_d   = chk_addr_q;
    pend_d       = pend_q;
    bit_d        = bit_q;
    res_status_d = res_status_q;
    res_block_d  = res_block_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_addr_q;
    ram_wdata    = '0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_block_d = '0;
          if (req_type_i == REQ_ALLOC) begin
            if (lim == '0) begin
              res_status_d = ST_FULL;
              state_d      = S_FIN;
            end else begin
              rd_addr_d = '0;
              pend_d    = 1'b0;
              state_d   = S_SCAN;
            end
          end else if (blk_ext >= lim) begin
            res_status_d = ST_RANGE;
            state_d      = S_FIN;
          end else begin
            rd_addr_d = blk_ext[LOG_WB +: AW];
            bit_d     = block_number_i[LOG_WB-1:0];
            state_d   = S_FRD;
          end
        end
      end
      S_SCAN: begin
        // read address runs one word ahead of the word under check
        rd_addr_d  = rd_addr_q + AW'(1);
        chk_addr_d = rd_addr_q;
        pend_d     = 1'b1;
        if (pend_q) begin
          if (scan_found) begin
            ram_we       = 1'b1;
            ram_wdata    = ram_rdata | scan_onehot;
            res_status_d = ST_OK;
            res_block_d  = base | CNT_W'(scan_idx);
            state_d      = S_FIN;
          end else if (last_word) begin
            res_status_d = ST_FULL;
            state_d      = S_FIN;
          end
        end
      end
      S_FRD: begin
        chk_addr_d = rd_addr_q;
        state_d    = S_FCHK;
      end
      S_FCHK: begin
        if ((ram_rdata & free_mask) == '0) begin
          res_status_d = ST_FREE;
        end else begin
          ram_we       = 1'b1;
          ram_wdata    = ram_rdata & ~free_mask;
          res_status_d = ST_OK;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_block_d  = out_block_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_block_d  = res_block_q[BLK_W-1:0];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= TOTAL_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= rd_addr_d;
    chk_addr_q   <= chk_addr_d;
    bit_q        <= bit_d;
    res_status_q <= res_status_d;
    res_block_q  <= res_block_d;
    out_status_q <= out_status_d;
    out_block_q  <= out_block_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_block_o = out_block_q;

endmodule

// File: design/bba_map_ram.sv
// ============================================================================
// bba_map_ram - usage bitmap storage
// One write port, one read port, registered read data.
// ============================================================================
module bba_map_ram #(
  parameter int WORD_BITS = 32,
  parameter int DEPTH     = 128,
  parameter int AW        = 7
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bba_scan.sv
// ============================================================================
// bba_scan - free-bit finder for one bitmap word
// Finds the lowest clear bit whose block number lies below the limit.
// ============================================================================
module bba_scan #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 13,
  parameter int LOG_WB    = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [CNT_W-1:0]     base_i,   // block number of bit 0
  input  logic [CNT_W-1:0]     lim_i,
  output logic                 found_o,
  output logic [LOG_WB-1:0]    idx_o,
  output logic [WORD_BITS-1:0] onehot_o
);

  logic [CNT_W-1:0]     rem;
  logic [WORD_BITS-1:0] in_range;
  logic [WORD_BITS-1:0] cand;
  logic [LOG_WB-1:0]    idx;

  assign rem = lim_i - base_i;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      in_range[i] = CNT_W'(i) < rem;
    end
  end

  assign cand     = ~word_i & in_range;
  // isolate lowest set bit
  assign onehot_o = cand & (~cand + WORD_BITS'(1));
  assign found_o  = |cand;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      idx = idx | (onehot_o[i] ? LOG_WB'(i) : LOG_WB'(0));
    end
  end

  assign idx_o = idx;

endmodule
